// File: src/hce_pkg.sv
// Shared types and constants for the Huffman code encoder.
`default_nettype none

package hce_pkg;

    // Field widths
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 7;
    localparam int PCNT_W      = 3;
    localparam int TABLE_DEPTH = 256;
    localparam int MAX_BYTES   = 4;
    localparam int NB_W        = 3;
    // Packing window: pending bits, one codeword, one spare bit
    localparam int ACC_W       = PEND_W + CODE_W + 1;
    localparam int OP_W        = 2;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 8;

    localparam int DEF_MAX_CODE_LEN = 32;

    // Item kinds carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // One code table entry; codeword stored left aligned (first bit in bit 31)
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

    // Item leaving the table read stage
    typedef struct packed {
        logic              vld;
        op_t               op;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } stage_t;

endpackage

`default_nettype wire

// File: src/hce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/hce_table.sv
// Code table: entry writes on load, lookup on encode, and the read stage register.
`default_nettype none

module hce_table
    import hce_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire op_t               op,
    input  wire logic [SYM_W-1:0]  sym,
    input  wire logic [CODE_W-1:0] code_bits,
    input  wire logic [LEN_W-1:0]  code_length,
    input  wire logic              advance,
    output stage_t                 stg
);

    localparam int LEN_LIMIT = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   hit_reg;
    logic                   vld_reg;
    op_t                    op_reg;
    logic                   we;
    logic                   re;
    logic [LEN_W-1:0]       len_sat;
    entry_t                 wr_entry;
    entry_t                 rd_entry;

    // Saturate the length and left align the codeword for storage
    always_comb begin
        len_sat = code_length;
        if (code_length > LEN_W'(LEN_LIMIT)) begin
            len_sat = LEN_W'(LEN_LIMIT);
        end
        wr_entry.len  = len_sat;
        wr_entry.code = code_bits << (LEN_W'(CODE_W) - len_sat);
    end

    assign we = accept && (op == OP_LOAD);
    assign re = accept && (op == OP_ENCODE);

    hce_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (sym),
        .wdata (wr_entry),
        .re    (re),
        .raddr (sym),
        .rdata (rd_entry)
    );

    // Per-entry written flags; an unwritten entry reads as length zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[sym] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            hit_reg <= valid_reg[sym];
        end
    end

    // Read stage occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (accept) begin
            vld_reg <= 1'b1;
        end else if (advance) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= op;
        end
    end

    assign stg.vld  = vld_reg;
    assign stg.op   = op_reg;
    assign stg.code = rd_entry.code;
    assign stg.len  = hit_reg ? rd_entry.len : '0;

endmodule

`default_nettype wire

// File: src/hce_packer.sv
// Bit packer: merges codewords with pending bits and drains whole bytes.
`default_nettype none

module hce_packer
    import hce_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire stage_t              stg,
    output logic                     advance,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                     m_tlast
);

    logic [PEND_W-1:0] pend_reg;      // left aligned, unused low bits zero
    logic [PEND_W-1:0] pend_next;
    logic [PCNT_W-1:0] pcnt_reg;
    logic [PCNT_W-1:0] pcnt_next;
    logic [BYTE_W-1:0] buf_reg [MAX_BYTES];
    logic [BYTE_W-1:0] buf_next [MAX_BYTES];
    logic [NB_W-1:0]   bcnt_reg;
    logic [ACC_W-1:0]  acc;
    logic [LEN_W-1:0]  tot;
    logic [NB_W-1:0]   nb;
    logic              upd;
    logic              emit;
    logic              can_load;
    logic              pop;

    assign pop      = m_tvalid && m_tready;
    assign can_load = (bcnt_reg == '0) || ((bcnt_reg == NB_W'(1)) && m_tready);

    // Pack pending bits and the codeword into one left-aligned window
    always_comb begin
        acc       = {pend_reg, {(ACC_W-PEND_W){1'b0}}}
                  | ({stg.code, {(ACC_W-CODE_W){1'b0}}} >> pcnt_reg);
        tot       = LEN_W'(pcnt_reg) + stg.len;
        upd       = 1'b0;
        nb        = '0;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        for (int k = 0; k < MAX_BYTES; k++) begin
            buf_next[k] = acc[ACC_W-1-BYTE_W*k -: BYTE_W];
        end
        case (stg.op)
            OP_ENCODE: begin
                if (stg.len != '0) begin
                    upd       = 1'b1;
                    nb        = tot[LEN_W-1:PCNT_W];
                    pcnt_next = tot[PCNT_W-1:0];
                    case (nb)
                        3'd0:    pend_next = acc[ACC_W-1 -: PEND_W];
                        3'd1:    pend_next = acc[ACC_W-1-BYTE_W -: PEND_W];
                        3'd2:    pend_next = acc[ACC_W-1-2*BYTE_W -: PEND_W];
                        3'd3:    pend_next = acc[ACC_W-1-3*BYTE_W -: PEND_W];
                        default: pend_next = acc[ACC_W-1-4*BYTE_W -: PEND_W];
                    endcase
                end
            end
            OP_FLUSH: begin
                if (pcnt_reg != '0) begin
                    upd         = 1'b1;
                    nb          = NB_W'(1);
                    buf_next[0] = {pend_reg, 1'b0};
                    pend_next   = '0;
                    pcnt_next   = '0;
                end
            end
            default: begin
            end
        endcase
        emit    = stg.vld && upd && (nb != '0);
        advance = !emit || can_load;
    end

    // Pending bit store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end else if (stg.vld && upd && advance) begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
        end
    end

    // Byte buffer count: loads a whole item's bytes, drains one per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcnt_reg <= '0;
        end else if (emit && can_load) begin
            bcnt_reg <= nb;
        end else if (pop) begin
            bcnt_reg <= bcnt_reg - NB_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit && can_load) begin
            buf_reg <= buf_next;
        end else if (pop) begin
            for (int k = 0; k < MAX_BYTES - 1; k++) begin
                buf_reg[k] <= buf_reg[k+1];
            end
        end
    end

    assign m_tvalid = (bcnt_reg != '0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (bcnt_reg == NB_W'(1));

endmodule

`default_nettype wire

// File: src/huffman_code_encoder.sv
// Top level of the Huffman code encoder with loadable code table.
`default_nettype none

// Huffman encoder with a 256-entry code table held in one synchronous RAM.
// Load items (tuser 0) write a symbol's codeword and length, encode items
// (tuser 1) look the symbol up and pack its code bits, flush items (tuser 2)
// pad pending bits to a byte. Each item passes through the pipeline: the table
// read, then packing into a byte buffer. One item is accepted per cycle as
// long as each encode or flush yields at most one byte and the output is
// ready; an item yielding more than one byte holds the next encode or flush
// that yields bytes until all but its last byte have left, longer while the
// output stalls, as the output drains one byte per transfer. Loads and encodes
// that yield no byte pass without waiting. Each item's final byte carries tlast.
// The table reads as empty after reset through per-entry written flags, so
// no clearing pass is needed. Codeword lengths are saturated to
// min(MAX_CODE_LEN, 32) on load.
module huffman_code_encoder
    import hce_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [7:0] symbol, [39:8] code_bits,
                                                // [45:40] code_length
    input  wire logic [OP_W-1:0]     s_tuser,   // [1:0] operation
    // Result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                     m_tlast
);

    logic   accept;
    logic   advance;
    stage_t stg;

    assign s_tready = !stg.vld || advance;
    assign accept   = s_tvalid && s_tready;

    hce_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (op_t'(s_tuser)),
        .sym         (s_tdata[SYM_W-1:0]),
        .code_bits   (s_tdata[SYM_W +: CODE_W]),
        .code_length (s_tdata[SYM_W+CODE_W +: LEN_W]),
        .advance     (advance),
        .stg         (stg)
    );

    hce_packer u_packer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stg      (stg),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: src/hce_checker.sv
// Port-level checks for the Huffman code encoder, bound to the top level.
`default_nettype none

module hce_checker
    import hce_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic                m_tlast
);

    // Nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A byte that is not the last of its item is followed by another byte
    a_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("item ended without a last byte");

    // Input is held off only while output bytes are waiting
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind huffman_code_encoder hce_checker u_hce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);

`default_nettype wire
